/* rtl/route_table_metric_lookup_assert.svh */
// Assertion macros used by the route table lookup controller.
`ifndef ROUTE_TABLE_METRIC_LOOKUP_ASSERT_SVH
`define ROUTE_TABLE_METRIC_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define RTML_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rtml: assertion failed");
// Next-cycle implication, checked out of reset.
`define RTML_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rtml: assertion failed");
`else
`define RTML_ASSERT_IMP(name, clk, rstn, ante, cons)
`define RTML_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

/* rtl/rtml_pkg.sv */
// Shared constants, types and codes of the route table lookup.
package rtml_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ADDR_W      = 32;
    localparam int METRIC_W    = 16;
    localparam int SLOT_W      = 4;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_LOOKUP = 1'b1
    } rtml_func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } rtml_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   dest;
        logic [ADDR_W-1:0]   mask;
        logic [METRIC_W-1:0] metric;
        logic                gateway;
    } rtml_entry_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic             accept;
        logic             scan_rd;
        logic [IDX_W-1:0] rd_idx;
        logic             load_out;
    } rtml_cmd_t;

endpackage

/* rtl/rtml_ctrl.sv */
// Controller state machine: handshakes, scan sequencing and output valid.
`include "route_table_metric_lookup_assert.svh"

module rtml_ctrl
    import rtml_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_func,
    output logic      m_valid,
    input  logic      m_ready,
    output rtml_cmd_t cmd
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    rtml_state_t      state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    cnt_next   = '0;
                    state_next = (s_func == FUNC_LOOKUP) ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                cmd.rd_idx  = cnt_reg;
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    `RTML_ASSERT_NEXT(a_lookup_starts_scan, aclk, aresetn,
        s_valid && s_ready && (s_func == FUNC_LOOKUP), state_reg == ST_SCAN && cnt_reg == '0)
    `RTML_ASSERT_NEXT(a_scan_ends_in_drain, aclk, aresetn,
        state_reg == ST_SCAN && cnt_reg == LAST_IDX, state_reg == ST_DRAIN)
    `RTML_ASSERT_IMP(a_load_only_when_free, aclk, aresetn,
        cmd.load_out, !m_valid_reg || m_ready)

endmodule

/* rtl/rtml_dp.sv */
// Datapath: route memory, valid bits, best-route trackers and result register.
module rtml_dp
    import rtml_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  rtml_cmd_t           cmd,
    input  logic                s_func,
    input  logic [SLOT_W-1:0]   s_slot,
    input  logic [ADDR_W-1:0]   s_entry_dest,
    input  logic [ADDR_W-1:0]   s_entry_mask,
    input  logic [METRIC_W-1:0] s_entry_metric,
    input  logic                s_entry_gateway,
    input  logic                s_entry_valid,
    input  logic [ADDR_W-1:0]   s_lookup_addr,
    output logic                m_found,
    output logic [SLOT_W-1:0]   m_route_index,
    output logic                m_via_default
);

    rtml_entry_t             mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  valid_reg;

    logic [IDX_W-1:0]        wr_idx;
    logic                    slot_ok;
    logic                    do_write;

    rtml_entry_t             rd_entry_reg;
    logic                    cmp_vld_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;

    logic [ADDR_W-1:0]       addr_reg;
    logic                    lookup_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic                    slot_ok_reg;

    logic                    have_match_reg, have_gw_reg;
    logic [IDX_W-1:0]        match_idx_reg, gw_idx_reg;
    logic [METRIC_W-1:0]     match_metric_reg, gw_metric_reg;

    logic                    cmp_live;
    logic                    hit;
    logic                    take_match, take_gw;

    logic                    found_reg;
    logic [SLOT_W-1:0]       index_reg;
    logic                    via_default_reg;

    assign wr_idx   = IDX_W'(s_slot);
    assign slot_ok  = 32'(s_slot) < 32'(TABLE_DEPTH);
    assign do_write = cmd.accept && (s_func == FUNC_WRITE) && slot_ok;

    // Route memory: one write port at accept, one registered read port for the scan.
    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[wr_idx] <= '{dest:    s_entry_dest,
                             mask:    s_entry_mask,
                             metric:  s_entry_metric,
                             gateway: s_entry_gateway};
        end
        if (cmd.scan_rd) begin
            rd_entry_reg <= mem[cmd.rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            if (do_write) begin
                valid_reg[wr_idx] <= s_entry_valid;
            end
            cmp_vld_reg <= cmd.scan_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_rd) begin
            cmp_idx_reg <= cmd.rd_idx;
        end
        if (cmd.accept) begin
            addr_reg    <= s_lookup_addr;
            lookup_reg  <= (s_func == FUNC_LOOKUP);
            slot_reg    <= s_slot;
            slot_ok_reg <= slot_ok;
        end
    end

    // Compare stage: strict less-than keeps the lowest slot on equal metrics.
    assign cmp_live   = cmp_vld_reg && valid_reg[cmp_idx_reg];
    assign hit        = ((addr_reg ^ rd_entry_reg.dest) & rd_entry_reg.mask) == '0;
    assign take_match = cmp_live && hit &&
                        (!have_match_reg || rd_entry_reg.metric < match_metric_reg);
    assign take_gw    = cmp_live && rd_entry_reg.gateway &&
                        (!have_gw_reg || rd_entry_reg.metric < gw_metric_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_match_reg <= 1'b0;
            have_gw_reg    <= 1'b0;
        end else if (cmd.accept) begin
            have_match_reg <= 1'b0;
            have_gw_reg    <= 1'b0;
        end else begin
            if (take_match) begin
                have_match_reg <= 1'b1;
            end
            if (take_gw) begin
                have_gw_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_match) begin
            match_idx_reg    <= cmp_idx_reg;
            match_metric_reg <= rd_entry_reg.metric;
        end
        if (take_gw) begin
            gw_idx_reg    <= cmp_idx_reg;
            gw_metric_reg <= rd_entry_reg.metric;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (!lookup_reg) begin
                found_reg       <= slot_ok_reg;
                index_reg       <= slot_reg;
                via_default_reg <= 1'b0;
            end else if (have_match_reg) begin
                found_reg       <= 1'b1;
                index_reg       <= SLOT_W'(match_idx_reg);
                via_default_reg <= 1'b0;
            end else if (have_gw_reg) begin
                found_reg       <= 1'b1;
                index_reg       <= SLOT_W'(gw_idx_reg);
                via_default_reg <= 1'b1;
            end else begin
                found_reg       <= 1'b0;
                index_reg       <= '0;
                via_default_reg <= 1'b0;
            end
        end
    end

    assign m_found       = found_reg;
    assign m_route_index = index_reg;
    assign m_via_default = via_default_reg;

endmodule

/* rtl/route_table_metric_lookup.sv */
// Top level of the route table with metric-based lookup.
//
//  channel | ports                              | request carries
//  --------+------------------------------------+---------------------------------
//  input   | s_valid / s_ready, s_* fields      | slot write or address lookup
//  result  | m_valid / m_ready, m_* fields      | found, route index, via default
//
//  A write request holds the block through its accept in ST_IDLE and its load in ST_RESULT.
//  A lookup request holds it through the accept, one memory read per slot from the single
//  read port in ST_SCAN, one compare stage (ST_DRAIN for the last slot), and the load.
//  Reset clears the valid bits at once; the other route fields stay unknown.
//  The result register holds while m_ready is low; a new request is still
//  taken, and its result waits until the register frees up.
module route_table_metric_lookup
    import rtml_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [SLOT_W-1:0]   s_slot,
    input  logic [ADDR_W-1:0]   s_entry_dest,
    input  logic [ADDR_W-1:0]   s_entry_mask,
    input  logic [METRIC_W-1:0] s_entry_metric,
    input  logic                s_entry_gateway,
    input  logic                s_entry_valid,
    input  logic [ADDR_W-1:0]   s_lookup_addr,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output logic [SLOT_W-1:0]   m_route_index,
    output logic                m_via_default
);

    rtml_cmd_t cmd;

    // Sequence accept, slot scan and result load.
    rtml_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Hold the table, track best match and best gateway, drive the result.
    rtml_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_func          (s_func),
        .s_slot          (s_slot),
        .s_entry_dest    (s_entry_dest),
        .s_entry_mask    (s_entry_mask),
        .s_entry_metric  (s_entry_metric),
        .s_entry_gateway (s_entry_gateway),
        .s_entry_valid   (s_entry_valid),
        .s_lookup_addr   (s_lookup_addr),
        .m_found         (m_found),
        .m_route_index   (m_route_index),
        .m_via_default   (m_via_default)
    );

endmodule
